/* rtl/core/sorted_priority_queue_assert.svh */
// Assertion macros for the sorted priority queue.
// Included by the RTL files that carry concurrent checks; no other dependency.
`ifndef SORTED_PRIORITY_QUEUE_ASSERT_SVH
`define SORTED_PRIORITY_QUEUE_ASSERT_SVH
`ifndef SYNTH
// Same-cycle implication, disabled during reset.
`define SPQ_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// Next-cycle implication, disabled during reset.
`define SPQ_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define SPQ_ASSERT_NOW(label, clk, rst, ante, cons, msg)
`define SPQ_ASSERT_NXT(label, clk, rst, ante, cons, msg)
`endif
`endif

/* rtl/core/spq_pkg.sv */
// Shared types and codes of the sorted priority queue.
// No dependencies; used by the channel interfaces and the top level.
package spq_pkg;

  typedef logic signed [15:0] data_t;

  // One stored task record.
  typedef struct packed {
    data_t rank;
    data_t prio;
    data_t start_x;
    data_t start_y;
    data_t end_x;
    data_t end_y;
  } rec_t;

  typedef logic [1:0] status_t;

  localparam logic    OP_INSERT = 1'b0;
  localparam logic    OP_POP    = 1'b1;

  localparam status_t ST_OK     = 2'd0;
  localparam status_t ST_EMPTY  = 2'd1;
  localparam status_t ST_FULL   = 2'd2;

endpackage

/* rtl/core/spq_if.sv */
// Request and response channel interfaces of the sorted priority queue.
// Depends on spq_pkg for the field types.
interface spq_in_if;
  import spq_pkg::*;

  logic  valid;
  logic  ready;
  logic  opcode;
  data_t task_rank;
  data_t task_priority;
  data_t start_x;
  data_t start_y;
  data_t end_x;
  data_t end_y;

  modport source (output valid, opcode, task_rank, task_priority, start_x, start_y,
                  end_x, end_y, input ready);
  modport sink   (input valid, opcode, task_rank, task_priority, start_x, start_y,
                  end_x, end_y, output ready);
endinterface

interface spq_out_if;
  import spq_pkg::*;

  logic       valid;
  logic       ready;
  status_t    status;
  data_t      out_rank;
  data_t      out_priority;
  data_t      out_start_x;
  data_t      out_start_y;
  data_t      out_end_x;
  data_t      out_end_y;
  logic [4:0] occupancy;

  modport source (output valid, status, out_rank, out_priority, out_start_x, out_start_y,
                  out_end_x, out_end_y, occupancy, input ready);
  modport sink   (input valid, status, out_rank, out_priority, out_start_x, out_start_y,
                  out_end_x, out_end_y, occupancy, output ready);
endinterface

/* rtl/core/sorted_priority_queue.sv */
// Sorted priority queue: records held in rank order in one record memory.
// Depends on spq_pkg, spq_if.sv and sorted_priority_queue_assert.svh.
//
//   channel | dir | handshake    | contents
//   --------+-----+--------------+------------------------------------------
//   req     | in  | valid/ready  | opcode, rank, priority, four coordinates
//   rsp     | out | valid/ready  | status, popped record, occupancy
//
// Records move one per cycle through the record memory. An insert into a
// partly filled queue shifts each record of larger rank up one slot, then writes the
// new record; a pop shifts those behind the head down; others skip the walk.
// Reset (synchronous, active high) empties the queue; memory is not cleared.
// A finished result waits in the response register while the next request is
// taken; a result stalls in its final step only while the previous one is held.
`include "sorted_priority_queue_assert.svh"

module sorted_priority_queue #(
  parameter int CAPACITY = 16
) (
  input logic      clk,
  input logic      rst,
  spq_in_if.sink   req,
  spq_out_if.source rsp
);
  import spq_pkg::*;

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_INS  = 6'b000010,
    S_PUT  = 6'b000100,
    S_HEAD = 6'b001000,
    S_POP  = 6'b010000,
    S_DONE = 6'b100000
  } state_t;

  state_t          state, state_next;
  logic [CW-1:0]   cnt, cnt_next;
  logic [AW-1:0]   idx, idx_next;
  rec_t            new_rec, new_rec_next;
  rec_t            res_rec, res_rec_next;
  status_t         res_status, res_status_next;
  logic            out_load;

  rec_t            mem [CAPACITY];
  rec_t            rd_data;
  rec_t            wr_data;
  logic [AW-1:0]   rd_addr;
  logic [AW-1:0]   wr_addr;
  logic            wr_en;

  logic [CW-1:0]   cnt_m1;
  logic [AW-1:0]   tail;
  logic [AW-1:0]   idx_inc;
  logic [AW-1:0]   idx_dec;
  rec_t            in_rec;

  assign cnt_m1  = cnt - CW'(1);
  assign tail    = cnt_m1[AW-1:0];
  assign idx_inc = idx + AW'(1);
  assign idx_dec = idx - AW'(1);

  assign in_rec = '{rank:    req.task_rank,
                    prio:    req.task_priority,
                    start_x: req.start_x,
                    start_y: req.start_y,
                    end_x:   req.end_x,
                    end_y:   req.end_y};

  assign req.ready = (state == S_IDLE);

  // Record memory: one write and one registered read per cycle.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

  // Sequencer: walks the stored records one per cycle.
  always_comb begin
    state_next      = state;
    cnt_next        = cnt;
    idx_next        = idx;
    new_rec_next    = new_rec;
    res_rec_next    = res_rec;
    res_status_next = res_status;
    rd_addr         = idx;
    wr_en           = 1'b0;
    wr_addr         = idx;
    wr_data         = rd_data;
    out_load        = 1'b0;
    case (state)
      S_IDLE: begin
        if (req.valid) begin
          new_rec_next    = in_rec;
          res_rec_next    = '0;
          res_status_next = ST_OK;
          if (req.opcode == OP_POP) begin
            if (cnt == '0) begin
              res_status_next = ST_EMPTY;
              state_next      = S_DONE;
            end else begin
              rd_addr    = '0;
              idx_next   = '0;
              state_next = S_HEAD;
            end
          end else begin
            if (cnt == CW'(CAPACITY)) begin
              res_status_next = ST_FULL;
              state_next      = S_DONE;
            end else if (cnt == '0) begin
              wr_en      = 1'b1;
              wr_addr    = '0;
              wr_data    = in_rec;
              cnt_next   = cnt + CW'(1);
              state_next = S_DONE;
            end else begin
              rd_addr    = tail;
              idx_next   = tail;
              state_next = S_INS;
            end
          end
        end
      end
      S_INS: begin
        // Move larger ranks up by one until the slot for the new record is found.
        wr_en   = 1'b1;
        wr_addr = idx_inc;
        if ($signed(rd_data.rank) > $signed(new_rec.rank)) begin
          wr_data = rd_data;
          if (idx == '0) begin
            state_next = S_PUT;
          end else begin
            idx_next = idx_dec;
            rd_addr  = idx_dec;
          end
        end else begin
          wr_data    = new_rec;
          cnt_next   = cnt + CW'(1);
          state_next = S_DONE;
        end
      end
      S_PUT: begin
        // The new record has the smallest rank and becomes the head.
        wr_en      = 1'b1;
        wr_addr    = '0;
        wr_data    = new_rec;
        cnt_next   = cnt + CW'(1);
        state_next = S_DONE;
      end
      S_HEAD: begin
        res_rec_next = rd_data;
        if (cnt == CW'(1)) begin
          cnt_next   = cnt_m1;
          state_next = S_DONE;
        end else begin
          idx_next   = AW'(1);
          rd_addr    = AW'(1);
          state_next = S_POP;
        end
      end
      S_POP: begin
        // Close the gap left by the head, one record per cycle.
        wr_en   = 1'b1;
        wr_addr = idx_dec;
        wr_data = rd_data;
        if (idx == tail) begin
          cnt_next   = cnt_m1;
          state_next = S_DONE;
        end else begin
          idx_next = idx_inc;
          rd_addr  = idx_inc;
        end
      end
      S_DONE: begin
        if (!rsp.valid || rsp.ready) begin
          out_load   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
  end

  // Working registers of the request in flight.
  always_ff @(posedge clk) begin
    idx        <= idx_next;
    new_rec    <= new_rec_next;
    res_rec    <= res_rec_next;
    res_status <= res_status_next;
  end

  // Response register.
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (out_load) begin
      rsp.valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      rsp.status       <= res_status;
      rsp.out_rank     <= res_rec.rank;
      rsp.out_priority <= res_rec.prio;
      rsp.out_start_x  <= res_rec.start_x;
      rsp.out_start_y  <= res_rec.start_y;
      rsp.out_end_x    <= res_rec.end_x;
      rsp.out_end_y    <= res_rec.end_y;
      rsp.occupancy    <= 5'(cnt);
    end
  end

  // Checks on the sequencer and the reported status.
  `SPQ_ASSERT_NOW(a_cnt_bound, clk, rst, 1'b1, cnt <= CW'(CAPACITY), "count above capacity")
  `SPQ_ASSERT_NXT(a_idle_cnt, clk, rst, state == S_IDLE && !req.valid, cnt == $past(cnt), "count moved in idle")
  `SPQ_ASSERT_NOW(a_walk_idx, clk, rst, state == S_INS || state == S_POP, CW'(idx) < cnt, "walk index beyond tail")
  `SPQ_ASSERT_NOW(a_full_occ, clk, rst, rsp.valid && rsp.status == ST_FULL, rsp.occupancy == 5'(CAPACITY), "full status with room left")
  `SPQ_ASSERT_NOW(a_empty_occ, clk, rst, rsp.valid && rsp.status == ST_EMPTY, rsp.occupancy == 5'd0, "empty status with records stored")

endmodule

/* bench/tb_top.sv */
// Self-checking regression for the sorted priority queue.
// Depends on spq_pkg, the spq_in_if/spq_out_if channel interfaces and the
// sorted_priority_queue top level.
`timescale 1ns / 1ps

module tb_top;
  import spq_pkg::*;

  localparam int CAPACITY     = 16;
  // The deliberate hold-off is the longest quiet stretch.
  localparam int HOLD_OFF     = 300;
  localparam int IDLE_LIMIT   = 2000;
  localparam int DRAIN_CYCLES = 40;
  localparam int RANDOM_COUNT = 1090;

  typedef struct {
    status_t    status;
    rec_t       rec;
    logic [4:0] occupancy;
  } queue_result_t;

  logic clk = 1'b0;
  logic rst;

  spq_in_if  req_ch ();
  spq_out_if rsp_ch ();

  sorted_priority_queue #(.CAPACITY(CAPACITY)) uut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  // Shadow copy of the stored records, head first, and the results still owed.
  rec_t          model_records[$];
  queue_result_t pending_results[$];
  queue_result_t oldest;

  int errors       = 0;
  int idle_cycles  = 0;
  int hold_request = 0;
  bit burst_mode   = 1'b0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Apply one accepted request to the shadow queue and queue up its result.
  function automatic void predict_queue_step(input logic op, input rec_t r);
    queue_result_t res;
    int pos;
    res.status = ST_OK;
    res.rec    = '0;
    if (op == OP_POP) begin
      if (model_records.size() == 0) res.status = ST_EMPTY;
      else res.rec = model_records.pop_front();
    end else if (model_records.size() >= CAPACITY) begin
      res.status = ST_FULL;
    end else begin
      // New record goes behind every record of equal or smaller rank.
      pos = 0;
      while (pos < model_records.size() &&
             $signed(model_records[pos].rank) <= $signed(r.rank))
        pos++;
      model_records.insert(pos, r);
    end
    res.occupancy = 5'(model_records.size());
    pending_results.push_back(res);
  endfunction

  // Sender gap: mostly none or short, now and then long.
  function automatic int pick_gap();
    int roll;
    if (burst_mode) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 60) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic rec_t make_record(input data_t rank, input data_t prio, input data_t sx,
                                       input data_t sy, input data_t ex, input data_t ey);
    rec_t r;
    r.rank    = rank;
    r.prio    = prio;
    r.start_x = sx;
    r.start_y = sy;
    r.end_x   = ex;
    r.end_y   = ey;
    return r;
  endfunction

  // Rank modes: 0 a narrow band full of ties, 1 full range, 2 the extremes.
  function automatic rec_t random_record(input int rank_mode);
    rec_t r;
    int pick;
    r = make_record('0, data_t'($urandom), data_t'($urandom), data_t'($urandom),
                    data_t'($urandom), data_t'($urandom));
    pick = $urandom_range(0, 6);
    case (rank_mode)
      0: begin
        r.rank = data_t'(pick - 3);
      end
      1: begin
        r.rank = data_t'($urandom);
      end
      default: begin
        case (pick)
          0: r.rank = data_t'(-32768);
          1: r.rank = data_t'(-32767);
          2: r.rank = data_t'(-1);
          3: r.rank = data_t'(0);
          4: r.rank = data_t'(1);
          5: r.rank = data_t'(32766);
          default: r.rank = data_t'(32767);
        endcase
      end
    endcase
    return r;
  endfunction

  // Offer one request, wait for the handshake, then predict its result.
  task automatic send_request(input logic op, input rec_t r);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_ch.valid         <= 1'b1;
    req_ch.opcode        <= op;
    req_ch.task_rank     <= r.rank;
    req_ch.task_priority <= r.prio;
    req_ch.start_x       <= r.start_x;
    req_ch.start_y       <= r.start_y;
    req_ch.end_x         <= r.end_x;
    req_ch.end_y         <= r.end_y;
    do @(posedge clk); while (!req_ch.ready);
    predict_queue_step(op, r);
  endtask

  task automatic check_field(input string name, input logic [15:0] exp_val,
                             input logic [15:0] act_val);
    if (exp_val !== act_val) begin
      $error("%s: expected 0x%h, got 0x%h", name, exp_val, act_val);
      errors++;
    end
  endtask

  // Popping right after reset finds nothing.
  task automatic test_empty_pop();
    repeat (2) send_request(OP_POP, random_record(1));
  endtask

  // Fill to capacity with extreme ranks, ties and new heads.
  task automatic test_sorted_fill();
    data_t fill_ranks [16] = '{0, 32767, -32768, 0, 5, 5, 5, -1,
                               32767, -32768, 100, -100, 1, -2, 0, 7};
    data_t patterns [6] = '{-32768, 32767, -1, 0, 21845, -21846};
    for (int i = 0; i < 16; i++)
      send_request(OP_INSERT, make_record(fill_ranks[i], patterns[i % 6],
                                          patterns[(i + 1) % 6], patterns[(i + 2) % 6],
                                          patterns[(i + 3) % 6], patterns[(i + 4) % 6]));
  endtask

  // Inserts into a full queue are dropped, even one with the smallest possible rank.
  task automatic test_full_insert();
    send_request(OP_INSERT, make_record(-32768, 1, 2, 3, 4, 5));
    send_request(OP_INSERT, make_record(32767, -1, -2, -3, -4, -5));
  endtask

  // Drain everything in rank order, then pop once more on empty.
  task automatic test_drain();
    repeat (CAPACITY + 1) send_request(OP_POP, random_record(1));
  endtask

  // The receiver holds off for a long stretch while requests keep coming.
  task automatic test_backpressure();
    hold_request = HOLD_OFF;
    burst_mode   = 1'b1;
    for (int i = 0; i < 24; i++)
      send_request((i % 3 == 2) ? OP_POP : OP_INSERT, random_record(0));
    burst_mode = 1'b0;
  endtask

  // Random traffic in phases that push occupancy up, down or hold it level.
  task automatic test_random_traffic(input int count);
    int insert_pct;
    int rank_mode;
    int phase_left;
    logic op;
    insert_pct = 50;
    rank_mode  = 0;
    phase_left = 0;
    for (int i = 0; i < count; i++) begin
      if (phase_left == 0) begin
        phase_left = $urandom_range(20, 120);
        case ($urandom_range(0, 2))
          0: insert_pct = 85;
          1: insert_pct = 15;
          default: insert_pct = 50;
        endcase
        rank_mode  = $urandom_range(0, 2);
        burst_mode = ($urandom_range(0, 3) == 0);
      end
      phase_left--;
      op = ($urandom_range(0, 99) < insert_pct) ? OP_INSERT : OP_POP;
      send_request(op, random_record(rank_mode));
    end
    burst_mode = 1'b0;
  endtask

  // Response ready: runs of ready, short stalls, rare long stalls, and the
  // requested hold-off counted here.
  initial begin
    int run_left;
    bit run_ready;
    int roll;
    run_left  = 0;
    run_ready = 1'b0;
    rsp_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_request > 0) begin
        run_left     = hold_request;
        run_ready    = 1'b0;
        hold_request = 0;
      end else if (run_left == 0) begin
        roll = $urandom_range(0, 99);
        if (roll < 55) begin
          run_ready = 1'b1;
          run_left  = $urandom_range(1, 24);
        end else if (roll < 90) begin
          run_ready = 1'b0;
          run_left  = $urandom_range(1, 3);
        end else begin
          run_ready = 1'b0;
          run_left  = $urandom_range(10, 40);
        end
      end
      rsp_ch.ready <= run_ready;
      run_left--;
    end
  end

  // Compare each accepted result with the oldest outstanding prediction.
  always @(posedge clk) begin
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      if (pending_results.size() == 0) begin
        $error("result arrived with no request outstanding");
        errors++;
      end else begin
        oldest = pending_results.pop_front();
        check_field("status", 16'(oldest.status), 16'(rsp_ch.status));
        check_field("out_rank", oldest.rec.rank, rsp_ch.out_rank);
        check_field("out_priority", oldest.rec.prio, rsp_ch.out_priority);
        check_field("out_start_x", oldest.rec.start_x, rsp_ch.out_start_x);
        check_field("out_start_y", oldest.rec.start_y, rsp_ch.out_start_y);
        check_field("out_end_x", oldest.rec.end_x, rsp_ch.out_end_x);
        check_field("out_end_y", oldest.rec.end_y, rsp_ch.out_end_y);
        check_field("occupancy", 16'(oldest.occupancy), 16'(rsp_ch.occupancy));
      end
    end
  end

  // Watchdog on cycles with no handshake on either channel.
  always @(posedge clk) begin
    if (rst || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("sorted_priority_queue regression: fail");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    rst                  <= 1'b1;
    req_ch.valid         <= 1'b0;
    req_ch.opcode        <= OP_INSERT;
    req_ch.task_rank     <= '0;
    req_ch.task_priority <= '0;
    req_ch.start_x       <= '0;
    req_ch.start_y       <= '0;
    req_ch.end_x         <= '0;
    req_ch.end_y         <= '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    test_empty_pop();
    test_sorted_fill();
    test_full_insert();
    test_drain();
    test_backpressure();
    test_random_traffic(RANDOM_COUNT);

    // Stop offering and let the outstanding results come back.
    req_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("sorted_priority_queue regression: pass");
    end else begin
      $display("sorted_priority_queue regression: fail");
    end
    $finish;
  end

endmodule
